>>> rtl/modbus_rtu_read_holding_master_core_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU read-holding master core
// Immediate-implication and next-cycle-implication checks on clk / arst_n.
// -----------------------------------------------------------------------------
`ifndef MODBUS_RTU_READ_HOLDING_MASTER_CORE_MACROS_SVH
`define MODBUS_RTU_READ_HOLDING_MASTER_CORE_MACROS_SVH

// same-cycle implication
`define MRH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mrh_pkg.sv
// -----------------------------------------------------------------------------
// mrh_pkg
// Shared types, codes and the CRC-16/Modbus byte update.
// -----------------------------------------------------------------------------
package mrh_pkg;

	localparam logic       IN_REQ  = 1'b0;
	localparam logic       IN_BYTE = 1'b1;

	localparam logic [1:0] OUT_TX     = 2'd0;
	localparam logic [1:0] OUT_REG    = 2'd1;
	localparam logic [1:0] OUT_STATUS = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SHORT   = 2'd1;
	localparam logic [1:0] ST_CRC     = 2'd2;
	localparam logic [1:0] ST_LENGTH  = 2'd3;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  FUNC_READ = 8'h03;
	localparam int unsigned MIN_FRAME = 5;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic        is_req;
		logic [7:0]  slave_address;
		logic [15:0] start_address;
		logic [15:0] register_count;
		logic        reg_v;
		logic [15:0] register_value;
		logic [6:0]  register_index;
		logic        st_v;
		logic [1:0]  status;
	} cmd_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

>>> rtl/mrh_front.sv
// -----------------------------------------------------------------------------
// mrh_front
// Accepts input transfers, tracks the response parser state and queues commands.
// -----------------------------------------------------------------------------
module mrh_front
	import mrh_pkg::*;
#(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        full,
	output logic        push,
	output cmd_t        cmd
);

	localparam int LEN_W = $clog2(MAX_FRAME + 2);
	localparam int CW    = LEN_W + 8;

	logic [15:0]      crc_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       held0_q, held1_q;
	logic [7:0]       dbc_q;
	logic [7:0]       pend_q;
	logic [6:0]       idx_q;

	logic             acc;
	logic [7:0]       b;
	logic [15:0]      crc_n;
	logic [LEN_W-1:0] len_n;
	logic [LEN_W-1:0] d;
	logic             in_data;
	logic             emit_reg;
	logic [1:0]       st;

	assign s_tready = !full;
	assign acc      = s_tvalid && s_tready;
	assign b        = s_tdata[47:40];

	always_comb begin
		crc_n    = (len_q >= LEN_W'(2)) ? crc_feed(crc_q, held0_q) : crc_q;
		len_n    = (len_q <= LEN_W'(MAX_FRAME)) ? len_q + LEN_W'(1) : len_q;
		d        = len_q - LEN_W'(3);
		in_data  = (len_q >= LEN_W'(3)) && (len_q < LEN_W'(MAX_FRAME))
			&& (CW'(d) < CW'(dbc_q));
		emit_reg = in_data && d[0];
		if (CW'(len_n) < CW'(MIN_FRAME))
			st = ST_SHORT;
		else if (len_n > LEN_W'(MAX_FRAME))
			st = ST_LENGTH;
		else if ({b, held1_q} != crc_n)
			st = ST_CRC;
		else if (CW'(len_n) != CW'(MIN_FRAME) + CW'(dbc_q))
			st = ST_LENGTH;
		else
			st = ST_OK;
	end

	always_comb begin
		cmd                = '0;
		cmd.is_req         = (s_tuser == IN_REQ);
		if (s_tuser == IN_REQ) begin
			cmd.slave_address  = s_tdata[7:0];
			cmd.start_address  = s_tdata[23:8];
			cmd.register_count = s_tdata[39:24];
			push               = acc;
		end else begin
			cmd.reg_v          = emit_reg;
			cmd.register_value = {pend_q, b};
			cmd.register_index = idx_q;
			cmd.st_v           = s_tlast;
			cmd.status         = st;
			push               = acc && (emit_reg || s_tlast);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			len_q   <= '0;
			held0_q <= '0;
			held1_q <= '0;
			dbc_q   <= '0;
			pend_q  <= '0;
			idx_q   <= '0;
		end else if (acc) begin
			if (s_tuser == IN_REQ || s_tlast) begin
				crc_q   <= CRC_INIT;
				len_q   <= '0;
				held0_q <= '0;
				held1_q <= '0;
				dbc_q   <= '0;
				pend_q  <= '0;
				idx_q   <= '0;
			end else begin
				crc_q   <= crc_n;
				len_q   <= len_n;
				held0_q <= held1_q;
				held1_q <= b;
				if (len_q == LEN_W'(2))
					dbc_q <= b;
				if (in_data && !d[0])
					pend_q <= b;
				if (emit_reg)
					idx_q <= idx_q + 7'd1;
			end
		end
	end

endmodule

>>> rtl/mrh_fifo.sv
// -----------------------------------------------------------------------------
// mrh_fifo
// Short command queue between the front and back parts.
// -----------------------------------------------------------------------------
module mrh_fifo
	import mrh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output logic head_v,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full   = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_v = (cnt_q != '0);
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
		end
	end

endmodule

>>> rtl/mrh_back.sv
// -----------------------------------------------------------------------------
// mrh_back
// Expands queued commands into output beats; serial CRC for request frames.
// -----------------------------------------------------------------------------
`include "modbus_rtu_read_holding_master_core_macros.svh"

module mrh_back
	import mrh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_v,
	input  cmd_t        head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic [2:0]  step_q;
	logic [15:0] crc_q;
	logic        load;
	logic        done;
	logic [7:0]  tx;
	logic [1:0]  kind;
	logic        lst;
	logic [39:0] data;

	assign load = head_v && (!m_tvalid || m_tready);
	assign pop  = load && done;

	always_comb begin
		case (step_q)
			3'd0:    tx = head.slave_address;
			3'd1:    tx = FUNC_READ;
			3'd2:    tx = head.start_address[15:8];
			3'd3:    tx = head.start_address[7:0];
			3'd4:    tx = head.register_count[15:8];
			3'd5:    tx = head.register_count[7:0];
			3'd6:    tx = crc_q[7:0];
			3'd7:    tx = crc_q[15:8];
			default: tx = '0;
		endcase
		data = '0;
		if (head.is_req) begin
			kind       = OUT_TX;
			data[7:0]  = tx;
			lst        = (step_q == 3'd7);
			done       = lst;
		end else if (step_q == 3'd0 && head.reg_v) begin
			kind        = OUT_REG;
			data[23:8]  = head.register_value;
			data[30:24] = head.register_index;
			lst         = 1'b0;
			done        = !head.st_v;
		end else begin
			kind        = OUT_STATUS;
			data[32:31] = head.status;
			lst         = 1'b1;
			done        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			step_q   <= '0;
			crc_q    <= CRC_INIT;
		end else if (load) begin
			m_tvalid <= 1'b1;
			step_q   <= done ? 3'd0 : step_q + 3'd1;
			if (head.is_req && step_q < 3'd6)
				crc_q <= crc_feed((step_q == 3'd0) ? CRC_INIT : crc_q, tx);
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= data;
			m_tuser <= kind;
			m_tlast <= lst;
		end
	end

	`MRH_ASSERT_NOW(a_status_last, m_tvalid && m_tuser == OUT_STATUS, m_tlast, "status beat without tlast")
	`MRH_ASSERT_NOW(a_tx_clean, m_tvalid && m_tuser == OUT_TX, m_tdata[39:8] == 32'd0, "tx beat carries stray fields")
	`MRH_ASSERT_NEXT(a_tx_wrap, load && head.is_req && step_q == 3'd7, step_q == 3'd0, "request sequencer did not wrap")

endmodule

>>> rtl/modbus_rtu_read_holding_master_core.sv
// -----------------------------------------------------------------------------
// modbus_rtu_read_holding_master_core
// Modbus RTU function 3 master: request framing with CRC-16, response parsing.
// -----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser     tlast
// s_*      in   slave[7:0] start[23:8] count[39:24]     kind      frame_end
//               rx_byte[47:40]
// m_*      out  tx[7:0] value[23:8] index[30:24]        out_kind  last
//               status[32:31]
//
// Response bytes are taken one per cycle unless the queue is full. A request
// gives eight output beats, one frame byte per cycle unless the output stalls;
// the back sequencer updates the CRC on the six header bytes. A frame end after
// a completed register gives a register and a status beat. A four-entry command
// queue lets input and output stall independently. Reset is asynchronous and immediate.
// -----------------------------------------------------------------------------
module modbus_rtu_read_holding_master_core
	import mrh_pkg::*;
#(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // slave_address, start_address, register_count, rx_byte
	input  logic        s_tuser,   // kind
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // tx_byte, register_value, register_index, status, pad
	output logic [1:0]  m_tuser,   // out_kind
	output logic        m_tlast
);

	logic full, push, pop, head_v;
	cmd_t wr_cmd, head;

	mrh_front #(.MAX_FRAME(MAX_FRAME)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.full     (full),
		.push     (push),
		.cmd      (wr_cmd)
	);

	mrh_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.pop    (pop),
		.head_v (head_v),
		.head   (head)
	);

	mrh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_v   (head_v),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> test/modbus_rtu_read_holding_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// modbus_rtu_read_holding_checker
// Watches both stream channels of the Modbus RTU read-holding master, keeps its
// own copy of the receive parser, predicts every output transfer from the
// accepted input transfers and compares them field by field, in order.
// -----------------------------------------------------------------------------
package modbus_tb_pkg;

	// bit-serial CRC-16/Modbus, LSB first
	function automatic logic [15:0] crc16_modbus_next(input logic [15:0] acc,
		input logic [7:0] data);
		logic [15:0] r;
		int k;
		r = acc;
		for (k = 0; k < 8; k++) begin
			r = {1'b0, r[15:1]} ^ ((r[0] ^ data[k]) ? mrh_pkg::CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

endpackage

module modbus_rtu_read_holding_checker
	import mrh_pkg::*;
	import modbus_tb_pkg::*;
#(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // slave_address, start_address, register_count, rx_byte
	input  logic        s_tuser,   // kind
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // tx_byte, register_value, register_index, status, pad
	input  logic [1:0]  m_tuser,   // out_kind
	input  logic        m_tlast,
	output int          errors,
	output int          due_count,
	output int          reg_words,
	output int          status_items
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx;
		logic [15:0] value;
		logic [6:0]  index;
		logic [1:0]  status;
		logic        last;
	} out_beat_t;

	out_beat_t   due_q[$];

	// receive parser copy
	logic [15:0] rx_crc_acc;
	logic [8:0]  rx_count;
	logic [7:0]  lag_byte [2];
	logic [7:0]  byte_cnt;
	logic [7:0]  hi_byte;
	logic [6:0]  reg_no;

	task automatic clear_parse();
		rx_crc_acc  = CRC_INIT;
		rx_count    = '0;
		lag_byte[0] = '0;
		lag_byte[1] = '0;
		byte_cnt    = '0;
		hi_byte     = '0;
		reg_no      = '0;
	endtask

	task automatic push_beat(input logic [1:0] kind, input logic [7:0] tx,
		input logic [15:0] value, input logic [6:0] index, input logic [1:0] status,
		input logic last);
		out_beat_t b;
		b.kind   = kind;
		b.tx     = tx;
		b.value  = value;
		b.index  = index;
		b.status = status;
		b.last   = last;
		due_q = {due_q, b};
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v,
		input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_beat_t   got;
		out_beat_t   want;
		logic [7:0]  frame [8];
		logic [15:0] crc;
		logic [7:0]  b;
		logic [1:0]  st;
		int          p;
		int          d;
		int          i;
		if (!arst_n) begin
			clear_parse();
			due_q.delete();
			errors       = 0;
			due_count    = 0;
			reg_words    = 0;
			status_items = 0;
		end else begin
			// output side first: a transfer leaving now stems from an earlier input
			if (m_tvalid && m_tready) begin
				got.kind   = m_tuser;
				got.tx     = m_tdata[7:0];
				got.value  = m_tdata[23:8];
				got.index  = m_tdata[30:24];
				got.status = m_tdata[32:31];
				got.last   = m_tlast;
				if (got.kind == OUT_REG)
					reg_words++;
				if (got.kind == OUT_STATUS)
					status_items++;
				if (due_q.size() == 0) begin
					$error("output transfer with nothing expected: kind %0h tdata 0x%0h",
						got.kind, m_tdata);
					errors++;
				end else begin
					want = due_q.pop_front();
					check_field("out_kind", 16'(want.kind), 16'(got.kind));
					check_field("tx_byte", 16'(want.tx), 16'(got.tx));
					check_field("register_value", want.value, got.value);
					check_field("register_index", 16'(want.index), 16'(got.index));
					check_field("status", 16'(want.status), 16'(got.status));
					check_field("last", 16'(want.last), 16'(got.last));
				end
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == IN_REQ) begin
					clear_parse();
					frame[0] = s_tdata[7:0];
					frame[1] = FUNC_READ;
					frame[2] = s_tdata[23:16];
					frame[3] = s_tdata[15:8];
					frame[4] = s_tdata[39:32];
					frame[5] = s_tdata[31:24];
					crc = CRC_INIT;
					for (i = 0; i < 6; i++)
						crc = crc16_modbus_next(crc, frame[i]);
					frame[6] = crc[7:0];
					frame[7] = crc[15:8];
					for (i = 0; i < 8; i++)
						push_beat(OUT_TX, frame[i], '0, '0, ST_OK, i == 7);
				end else begin
					b = s_tdata[47:40];
					p = int'(rx_count);
					// CRC runs two bytes behind so the trailer stays out of it
					if (p >= 2)
						rx_crc_acc = crc16_modbus_next(rx_crc_acc, lag_byte[0]);
					lag_byte[0] = lag_byte[1];
					lag_byte[1] = b;
					if (p == 2) begin
						byte_cnt = b;
					end else if (p >= 3 && p < MAX_FRAME) begin
						d = p - 3;
						if (d < byte_cnt) begin
							if (d % 2 == 0) begin
								hi_byte = b;
							end else begin
								push_beat(OUT_REG, '0, {hi_byte, b}, reg_no, ST_OK, 1'b0);
								reg_no = reg_no + 7'd1;
							end
						end
					end
					if (p <= MAX_FRAME)
						rx_count = 9'(p + 1);
					if (s_tlast) begin
						if (rx_count < MIN_FRAME)
							st = ST_SHORT;
						else if (rx_count > MAX_FRAME)
							st = ST_LENGTH;
						else if ({lag_byte[1], lag_byte[0]} != rx_crc_acc)
							st = ST_CRC;
						else if (rx_count != MIN_FRAME + byte_cnt)
							st = ST_LENGTH;
						else
							st = ST_OK;
						push_beat(OUT_STATUS, '0, '0, '0, st, 1'b1);
						clear_parse();
					end
				end
			end
			due_count = due_q.size();
		end
	end

endmodule

>>> test/tb_modbus_rtu_read_holding_master_core.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_modbus_rtu_read_holding_master_core
// Drives read requests and response byte streams (good frames, damaged CRC,
// truncated, wrong byte count, noise) into the master core with random stalls
// on both channels; the checker does the rest.
// -----------------------------------------------------------------------------
module tb_modbus_rtu_read_holding_master_core;
	import mrh_pkg::*;
	import modbus_tb_pkg::*;

	localparam int FRAME_LIMIT    = 256;
	localparam int RANDOM_ITEMS   = 200;
	localparam int CALM_TAIL      = 40;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef enum {INTACT, CRC_HIT, CUT_SHORT} damage_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int errors;
	int due_count;
	int reg_words;
	int status_items;

	bit idle_on       = 1'b1;
	int items_sent    = 0;
	int requests_sent = 0;
	int bytes_sent    = 0;
	int stall_left    = 0;
	int quiet_run     = 0;

	modbus_rtu_read_holding_master_core #(
		.MAX_FRAME(FRAME_LIMIT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	modbus_rtu_read_holding_checker #(
		.MAX_FRAME(FRAME_LIMIT)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.due_count   (due_count),
		.reg_words   (reg_words),
		.status_items(status_items)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// sink side back-pressure
	initial begin
		forever begin
			@(negedge clk);
			if (!idle_on) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = int'($urandom_range(1, 16)) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ends the run after too many cycles without any transfer
	initial begin
		while (quiet_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_run = 0;
			else
				quiet_run++;
		end
		$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	task automatic send_item(input logic kind, input logic [7:0] slave,
		input logic [15:0] start, input logic [15:0] count, input logic [7:0] rxb,
		input logic fend);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = int'($urandom_range(1, 16));
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tlast  <= fend;
		s_tdata  <= {rxb, count, start, slave};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_request(input logic [7:0] slave, input logic [15:0] start,
		input logic [15:0] count);
		send_item(IN_REQ, slave, start, count, 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
		requests_sent++;
	endtask

	task automatic send_rx(input logic [7:0] b, input logic fend);
		send_item(IN_BYTE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), b, fend);
		bytes_sent++;
	endtask

	task automatic send_response(input int bc_field, input int n_data,
		input damage_t damage);
		logic [7:0]  fb[$];
		logic [15:0] crc;
		int          pos;
		int          cut;
		fb = {fb, 8'($urandom_range(0, 255))};
		// function code is not checked by the block, so vary it now and then
		fb = {fb, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : FUNC_READ};
		fb = {fb, bc_field[7:0]};
		repeat (n_data) fb = {fb, 8'($urandom_range(0, 255))};
		crc = CRC_INIT;
		foreach (fb[i])
			crc = crc16_modbus_next(crc, fb[i]);
		fb = {fb, crc[7:0]};
		fb = {fb, crc[15:8]};
		if (damage == CRC_HIT) begin
			pos = int'($urandom_range(0, fb.size() - 1));
			fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
		end else if (damage == CUT_SHORT) begin
			cut = int'($urandom_range(1, 4));
			while (fb.size() > cut)
				void'(fb.pop_back());
		end
		foreach (fb[i])
			send_rx(fb[i], i == fb.size() - 1);
	endtask

	initial begin
		int base;
		int pick;
		int bc;
		int n;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		send_request(8'h00, 16'h0000, 16'h0000);
		send_request(8'hFF, 16'hFFFF, 16'hFFFF);
		send_response(0, 0, INTACT);
		send_response(2, 2, INTACT);
		send_rx(8'hA5, 1'b1);
		send_response(1, 1, CRC_HIT);
		send_response(4, 2, INTACT);

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			if (items_sent - base >= RANDOM_ITEMS - CALM_TAIL)
				idle_on = 1'b0;
			pick = int'($urandom_range(0, 99));
			if (pick < 15) begin
				send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
			end else if (pick < 75) begin
				bc = int'($urandom_range(0, 10));
				n  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 12)) : bc;
				send_response(bc, n, (pick < 65) ? INTACT : ((pick < 70) ? CRC_HIT : CUT_SHORT));
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 6))
					send_rx(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else begin
				// partial response cut off by a new request
				repeat ($urandom_range(1, 8))
					send_rx(8'($urandom_range(0, 255)), 1'b0);
				send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_count != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);

		$display("covered %0d requests and %0d response bytes, incl. damaged and cut frames",
			requests_sent, bytes_sent);
		$display("checked %0d register words and %0d status items", reg_words, status_items);
		if (errors == 0 && due_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
